// ----- sv/ipds_pkg.sv -----
// Shared types, widths and register codes of the incremental PD steering block.
package ipds_pkg;

  localparam int unsigned ErrW     = 16;               // error sample, Q4.12
  localparam int unsigned GainW    = 16;               // gains, Q8.8
  localparam int unsigned CeilW    = 15;               // error ceiling, unsigned Q3.12
  localparam int unsigned LimW     = 16;               // drive limit, Q8.8
  localparam int unsigned CfgDataW = 16;               // widest register
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned D1W      = ErrW + 1;         // e - e1
  localparam int unsigned D2W      = ErrW + 2;         // e - 2*e1 + e2
  localparam int unsigned ProdPW   = GainW + 1 + D1W;  // signed gain times d1
  localparam int unsigned ProdDW   = GainW + 1 + D2W;  // signed gain times d2
  localparam int unsigned RawW     = ProdDW + 1;
  localparam int unsigned FracBits = 12;
  localparam int unsigned IncW     = RawW - FracBits;
  localparam int unsigned AccW     = 32;
  localparam int unsigned MagW     = 16;
  localparam int unsigned OutDataW = 24;               // magnitude, direction, zero fill

  localparam logic [GainW-1:0] GainPReset = 16'd9779;
  localparam logic [GainW-1:0] GainDReset = 16'd717;
  localparam logic [CeilW-1:0] CeilReset  = 15'd6144;
  localparam logic [LimW-1:0]  LimReset   = 16'd25600;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN_P        = 2'd0,
    REG_GAIN_D        = 2'd1,
    REG_ERROR_CEILING = 2'd2,
    REG_DRIVE_LIMIT   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [GainW-1:0] gain_p;
    logic [GainW-1:0] gain_d;
    logic [CeilW-1:0] error_ceiling;
    logic [LimW-1:0]  drive_limit;
  } cfg_t;

endpackage

// ----- sv/incremental_pd_steering_core.sv -----
// Incremental PD steering controller: one error request in, one drive request out,
// accepted at one per clock while the result is not stalled. A request passes from
// acceptance to the result register through six register stages: input register, clamp
// and error differences, gain products, rounded increment, saturating accumulator, then
// limit to the drive magnitude and direction. The accumulator register adds one
// increment per cycle while the pipeline advances. All stages advance together; a
// stalled result holds the whole pipeline and input ready follows the output side. The
// user must write registers only while the block is idle; the block does not enforce it.
module incremental_pd_steering_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ipds_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [ipds_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [ipds_pkg::ErrW-1:0]          s_axis_tdata,   // [15:0] error_sample
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [ipds_pkg::OutDataW-1:0]      m_axis_tdata    // [15:0] drive_magnitude,
                                                             // [16] turn_right, [23:17] zero
);

  ipds_pkg::cfg_t                     cfg;
  logic                               adv;
  logic                               inc_valid;
  logic signed [ipds_pkg::IncW-1:0]   inc;
  logic [ipds_pkg::MagW-1:0]          drive_magnitude;
  logic                               turn_right;

  // Advance every stage unless a result is waiting to be taken.
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  ipds_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ipds_incr u_incr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (s_axis_tvalid),
    .err_i       ($signed(s_axis_tdata)),
    .cfg_i       (cfg),
    .inc_valid_o (inc_valid),
    .inc_o       (inc)
  );

  ipds_accum u_accum (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .adv_i             (adv),
    .inc_valid_i       (inc_valid),
    .inc_i             (inc),
    .drive_limit_i     (cfg.drive_limit),
    .out_valid_o       (m_axis_tvalid),
    .drive_magnitude_o (drive_magnitude),
    .turn_right_o      (turn_right)
  );

  assign m_axis_tdata = {(ipds_pkg::OutDataW - ipds_pkg::MagW - 1)'(0), turn_right,
                         drive_magnitude};

endmodule

// ----- sv/ipds_cfg_regs.sv -----
// Configuration register file: gains, error ceiling and drive limit.
module ipds_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ipds_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [ipds_pkg::CfgDataW-1:0]      cfg_wdata_i,
  output ipds_pkg::cfg_t                     cfg_o
);

  ipds_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p        <= ipds_pkg::GainPReset;
      cfg_q.gain_d        <= ipds_pkg::GainDReset;
      cfg_q.error_ceiling <= ipds_pkg::CeilReset;
      cfg_q.drive_limit   <= ipds_pkg::LimReset;
    end else if (cfg_we_i) begin
      unique case (ipds_pkg::reg_idx_e'(cfg_index_i))
        ipds_pkg::REG_GAIN_P:        cfg_q.gain_p        <= cfg_wdata_i;
        ipds_pkg::REG_GAIN_D:        cfg_q.gain_d        <= cfg_wdata_i;
        ipds_pkg::REG_ERROR_CEILING: cfg_q.error_ceiling <= cfg_wdata_i[ipds_pkg::CeilW-1:0];
        ipds_pkg::REG_DRIVE_LIMIT:   cfg_q.drive_limit   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- sv/ipds_incr.sv -----
// Input register, error clamp and history, gain products and rounded increment.
module ipds_incr (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               adv_i,
  input  logic                               in_valid_i,
  input  logic signed [ipds_pkg::ErrW-1:0]   err_i,
  input  ipds_pkg::cfg_t                     cfg_i,
  output logic                               inc_valid_o,
  output logic signed [ipds_pkg::IncW-1:0]   inc_o
);

  localparam int unsigned ErrW = ipds_pkg::ErrW;

  logic v0_q, v1_q, v2_q, v3_q;

  logic signed [ErrW-1:0]             err_q;
  logic signed [ErrW-1:0]             prev_q, pprev_q;
  logic signed [ipds_pkg::D1W-1:0]    d1_q;
  logic signed [ipds_pkg::D2W-1:0]    d2_q;
  logic signed [ipds_pkg::ProdPW-1:0] prod_p_q;
  logic signed [ipds_pkg::ProdDW-1:0] prod_d_q;
  logic signed [ipds_pkg::IncW-1:0]   inc_q;

  logic signed [ErrW-1:0]              ceil_s;
  logic signed [ErrW-1:0]              err_clamped;
  logic signed [ipds_pkg::D1W-1:0]     d1_d;
  logic signed [ipds_pkg::D2W-1:0]     d2_d;
  logic signed [ipds_pkg::GainW:0]     gain_p_s, gain_d_s;
  logic signed [ipds_pkg::ProdPW-1:0]  prod_p_d;
  logic signed [ipds_pkg::ProdDW-1:0]  prod_d_d;
  logic signed [ipds_pkg::RawW-1:0]    raw;

  // Clamp from above only; no lower clamp.
  assign ceil_s      = $signed({1'b0, cfg_i.error_ceiling});
  assign err_clamped = (err_q > ceil_s) ? ceil_s : err_q;

  assign d1_d = ipds_pkg::D1W'(err_clamped) - ipds_pkg::D1W'(prev_q);
  assign d2_d = ipds_pkg::D2W'(err_clamped) - (ipds_pkg::D2W'(prev_q) <<< 1)
              + ipds_pkg::D2W'(pprev_q);

  assign gain_p_s = $signed({1'b0, cfg_i.gain_p});
  assign gain_d_s = $signed({1'b0, cfg_i.gain_d});
  assign prod_p_d = gain_p_s * d1_q;
  assign prod_d_d = gain_d_s * d2_q;

  // Round half up, then drop the fraction bits (floor).
  assign raw = ipds_pkg::RawW'(prod_p_q) + ipds_pkg::RawW'(prod_d_q)
             + ipds_pkg::RawW'(1 << (ipds_pkg::FracBits - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      prev_q  <= '0;
      pprev_q <= '0;
    end else if (adv_i) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (v0_q) begin
        prev_q  <= err_clamped;
        pprev_q <= prev_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      err_q    <= err_i;
      d1_q     <= d1_d;
      d2_q     <= d2_d;
      prod_p_q <= prod_p_d;
      prod_d_q <= prod_d_d;
      inc_q    <= raw[ipds_pkg::RawW-1:ipds_pkg::FracBits];
    end
  end

  assign inc_valid_o = v3_q;
  assign inc_o       = inc_q;

endmodule

// ----- sv/ipds_accum.sv -----
// Saturating output accumulator and the limited magnitude / direction result register.
module ipds_accum (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               adv_i,
  input  logic                               inc_valid_i,
  input  logic signed [ipds_pkg::IncW-1:0]   inc_i,
  input  logic [ipds_pkg::LimW-1:0]          drive_limit_i,
  output logic                               out_valid_o,
  output logic [ipds_pkg::MagW-1:0]          drive_magnitude_o,
  output logic                               turn_right_o
);

  localparam int unsigned AccW = ipds_pkg::AccW;

  logic                    v4_q, vout_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [AccW-1:0]  acc_d;
  logic signed [AccW:0]    acc_sum;
  logic signed [AccW:0]    acc_abs;
  logic [AccW-1:0]         abs_mag;
  logic [ipds_pkg::MagW-1:0] mag_d, mag_q;
  logic                    dir_q;

  assign acc_sum = (AccW + 1)'(acc_q) + (AccW + 1)'(inc_i);

  // Saturate at the signed accumulator width.
  always_comb begin
    if (acc_sum[AccW] != acc_sum[AccW-1]) begin
      acc_d = acc_sum[AccW] ? {1'b1, {(AccW - 1){1'b0}}} : {1'b0, {(AccW - 1){1'b1}}};
    end else begin
      acc_d = acc_sum[AccW-1:0];
    end
  end

  assign acc_abs = acc_q[AccW-1] ? -((AccW + 1)'(acc_q)) : (AccW + 1)'(acc_q);
  assign abs_mag = acc_abs[AccW-1:0];
  assign mag_d   = (abs_mag > AccW'(drive_limit_i)) ? drive_limit_i
                                                    : abs_mag[ipds_pkg::MagW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q   <= 1'b0;
      vout_q <= 1'b0;
      acc_q  <= '0;
    end else if (adv_i) begin
      v4_q   <= inc_valid_i;
      vout_q <= v4_q;
      if (inc_valid_i) begin
        acc_q <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mag_q <= mag_d;
      dir_q <= acc_q[AccW-1];
    end
  end

  assign out_valid_o       = vout_q;
  assign drive_magnitude_o = mag_q;
  assign turn_right_o      = dir_q;

endmodule

// ----- sv/ipds_checker.sv -----
// Port-level checks of the steering core, bound to the top level.
module ipds_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [ipds_pkg::OutDataW-1:0]      m_axis_tdata
);

  // Hold a stalled result request.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Empty result register never refuses an input request.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input refused with empty output");

  // Stalled output holds back the input side.
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while output stalled");

  // No result appears straight out of reset.
  a_no_early_result: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid ##1 !m_axis_tvalid)
    else $error("result out of reset without input");

endmodule

bind incremental_pd_steering_core ipds_checker u_ipds_checker (.*);

// ----- tb/testbench.sv -----
// Self-checking testbench for the incremental PD steering core.
module testbench;

  localparam int QuietLimit = 5000;
  localparam int ReportMax  = 10;
  localparam int RandPhases = 5;
  localparam int PhaseItems = 236;
  localparam int PumpSteps  = 4;

  typedef struct packed {
    logic                      right;
    logic [ipds_pkg::MagW-1:0] mag;
  } drive_t;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          cfg_we_i      = 1'b0;
  logic [ipds_pkg::CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [ipds_pkg::CfgDataW-1:0] cfg_wdata_i   = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [ipds_pkg::ErrW-1:0]     s_axis_tdata  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [ipds_pkg::OutDataW-1:0] m_axis_tdata;

  incremental_pd_steering_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [15:0] error_sample
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // [15:0] drive_magnitude, [16] turn_right, [23:17] zero
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Controller copy: configuration and state as the block holds them
  logic [ipds_pkg::GainW-1:0]       kp_q   = ipds_pkg::GainPReset;
  logic [ipds_pkg::GainW-1:0]       kd_q   = ipds_pkg::GainDReset;
  logic [ipds_pkg::CeilW-1:0]       ceil_q = ipds_pkg::CeilReset;
  logic [ipds_pkg::LimW-1:0]        lim_q  = ipds_pkg::LimReset;
  logic signed [ipds_pkg::ErrW-1:0] err_d1 = '0;
  logic signed [ipds_pkg::ErrW-1:0] err_d2 = '0;
  logic signed [ipds_pkg::AccW-1:0] acc_q  = '0;

  logic [ipds_pkg::ErrW-1:0] err_pending[$];
  drive_t                    drive_expected[$];
  int                        queued_cnt   = 0;
  int                        accepted_cnt = 0;
  int                        err_count    = 0;
  int                        quiet_cycles = 0;
  int                        burst_left   = 1;
  int                        gap_left     = 0;
  int                        pat_left     = 0;
  logic [15:0]               stall_pat    = 16'hFFFF;
  logic [ipds_pkg::ErrW-1:0] last_err     = '0;

  // Advance the controller by one error sample and return the drive it yields.
  function automatic drive_t steer_step(logic [ipds_pkg::ErrW-1:0] sample);
    longint e, d1, d2, prod, inc, acc_next, lim;
    drive_t res;
    e = longint'($signed(sample));
    if (e > longint'(ceil_q)) e = longint'(ceil_q);
    d1   = e - err_d1;
    d2   = e - 2 * err_d1 + err_d2;
    prod = longint'(kp_q) * d1 + longint'(kd_q) * d2;
    inc  = (prod + (64'sd1 <<< (ipds_pkg::FracBits - 1))) >>> ipds_pkg::FracBits;
    acc_next = acc_q + inc;
    if (acc_next > 64'sh7FFF_FFFF) acc_next = 64'sh7FFF_FFFF;
    if (acc_next < -64'sh8000_0000) acc_next = -64'sh8000_0000;
    acc_q  = acc_next[ipds_pkg::AccW-1:0];
    err_d2 = err_d1;
    err_d1 = e[ipds_pkg::ErrW-1:0];
    lim = acc_next;
    if (acc_next < 0) begin
      if (lim < -longint'(lim_q)) lim = -longint'(lim_q);
      lim = -lim;
      res.right = 1'b1;
    end else begin
      if (lim > longint'(lim_q)) lim = longint'(lim_q);
      res.right = 1'b0;
    end
    res.mag = lim[ipds_pkg::MagW-1:0];
    return res;
  endfunction

  // Sender: bursts of random length separated by random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left > 0) begin
        gap_left      <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (err_pending.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= err_pending.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: rotate a stall pattern, swap it for a new one now and then
  always @(posedge clk_i) begin
    if (pat_left == 0) begin
      pat_left <= $urandom_range(16, 200);
      case ($urandom_range(0, 3))
        0:       stall_pat <= 16'hFFFF;
        1:       stall_pat <= 16'($urandom()) & 16'($urandom()) | 16'h0001;
        default: stall_pat <= 16'($urandom()) | 16'h0001;
      endcase
    end else begin
      pat_left  <= pat_left - 1;
      stall_pat <= {stall_pat[0], stall_pat[15:1]};
    end
    m_axis_tready <= stall_pat[0];
  end

  // Monitor: predict on each error request, check each drive request, watch for a hang
  always @(posedge clk_i) begin
    drive_t want;
    drive_t got;
    if (s_axis_tvalid && s_axis_tready) begin
      drive_expected.push_back(steer_step(s_axis_tdata));
      accepted_cnt++;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      got = drive_t'(m_axis_tdata[16:0]);
      if (drive_expected.size() == 0) begin
        if (err_count < ReportMax)
          $display("unexpected drive: mag=%0d right=%0b", got.mag, got.right);
        err_count++;
      end else begin
        want = drive_expected.pop_front();
        if (got.mag !== want.mag || got.right !== want.right ||
            m_axis_tdata[ipds_pkg::OutDataW-1:17] !== '0) begin
          if (err_count < ReportMax)
            $display("drive mismatch: exp mag=%0d right=%0b, got mag=%0d right=%0b fill=%h",
                     want.mag, want.right, got.mag, got.right,
                     m_axis_tdata[ipds_pkg::OutDataW-1:17]);
          err_count++;
        end
      end
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(ipds_pkg::reg_idx_e idx, logic [ipds_pkg::CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      ipds_pkg::REG_GAIN_P:        kp_q   = val[ipds_pkg::GainW-1:0];
      ipds_pkg::REG_GAIN_D:        kd_q   = val[ipds_pkg::GainW-1:0];
      ipds_pkg::REG_ERROR_CEILING: ceil_q = val[ipds_pkg::CeilW-1:0];
      ipds_pkg::REG_DRIVE_LIMIT:   lim_q  = val[ipds_pkg::LimW-1:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_error(logic [ipds_pkg::ErrW-1:0] val);
    err_pending.push_back(val);
    queued_cnt++;
  endtask

  // Hold until every request is through and the pipeline has drained
  task automatic wait_idle();
    while (accepted_cnt != queued_cnt || drive_expected.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 4))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 1023));
      default: return 16'($urandom());
    endcase
  endfunction

  // Mostly plausible heading errors, with holds, extremes and values near the ceiling
  function automatic logic [ipds_pkg::ErrW-1:0] pick_error();
    case ($urandom_range(0, 6))
      0, 1:    last_err = 16'($urandom());
      2:       last_err = 16'($signed($urandom_range(0, 1023)) - 512);
      3:       last_err = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
      4:       last_err = 16'(ceil_q) + 16'($signed($urandom_range(0, 8)) - 4);
      5:       last_err = last_err + 16'($signed($urandom_range(0, 255)) - 128);
      default: ; // hold the last error
    endcase
    return last_err;
  endfunction

  // Drive the accumulator one big step up or down: settle the history with zero gains,
  // then take the largest error swing at full gains.
  task automatic pump_acc(bit upward);
    write_reg(ipds_pkg::REG_GAIN_P, 16'd0);
    write_reg(ipds_pkg::REG_GAIN_D, 16'd0);
    send_error(upward ? 16'h7FFF : 16'h8000);
    send_error(upward ? 16'h8000 : 16'h7FFF);
    wait_idle();
    write_reg(ipds_pkg::REG_GAIN_P, 16'hFFFF);
    write_reg(ipds_pkg::REG_GAIN_D, 16'hFFFF);
    send_error(upward ? 16'h7FFF : 16'h8000);
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: zero error gives zero drive to the left, then extremes and the ceiling
    send_error(16'h0000);
    send_error(16'h0001);
    send_error(16'hFFFF);
    send_error(16'h7FFF);
    send_error(16'h8000);
    send_error(16'd6143);
    send_error(16'd6144);
    send_error(16'd6145);
    send_error(16'h0000);
    send_error(16'h0000);
    wait_idle();

    // Zero limit: magnitude stays zero, direction follows the accumulator
    write_reg(ipds_pkg::REG_DRIVE_LIMIT, 16'd0);
    send_error(16'd1000);
    send_error(16'hFC18);
    send_error(16'h8000);
    wait_idle();

    // Full gains, ceiling written with its unused top bit set, widest limit
    write_reg(ipds_pkg::REG_GAIN_P, 16'hFFFF);
    write_reg(ipds_pkg::REG_GAIN_D, 16'hFFFF);
    write_reg(ipds_pkg::REG_ERROR_CEILING, 16'hFFFF);
    write_reg(ipds_pkg::REG_DRIVE_LIMIT, 16'hFFFF);
    send_error(16'h7FFF);
    send_error(16'h8000);
    send_error(16'h7FFF);
    send_error(16'h0000);
    send_error(16'h0000);
    wait_idle();

    write_reg(ipds_pkg::REG_GAIN_P, 16'd0);
    write_reg(ipds_pkg::REG_GAIN_D, 16'd0);
    send_error(16'h1234);
    send_error(16'hEDCC);
    wait_idle();

    for (int ph = 0; ph < RandPhases; ph++) begin
      write_reg(ipds_pkg::REG_GAIN_P, pick_gain());
      write_reg(ipds_pkg::REG_GAIN_D, pick_gain());
      case ($urandom_range(0, 3))
        0:       write_reg(ipds_pkg::REG_ERROR_CEILING, 16'd0);
        1:       write_reg(ipds_pkg::REG_ERROR_CEILING, 16'h7FFF);
        2:       write_reg(ipds_pkg::REG_ERROR_CEILING, 16'($urandom_range(0, 8191)));
        default: write_reg(ipds_pkg::REG_ERROR_CEILING, 16'($urandom()));
      endcase
      case ($urandom_range(0, 3))
        0:       write_reg(ipds_pkg::REG_DRIVE_LIMIT, 16'd0);
        1:       write_reg(ipds_pkg::REG_DRIVE_LIMIT, 16'hFFFF);
        default: write_reg(ipds_pkg::REG_DRIVE_LIMIT, 16'($urandom()));
      endcase
      for (int n = 0; n < PhaseItems; n++)
        send_error(pick_error());
      wait_idle();
    end

    // Take the largest increments upward, then downward
    write_reg(ipds_pkg::REG_ERROR_CEILING, 16'h7FFF);
    write_reg(ipds_pkg::REG_DRIVE_LIMIT, 16'($urandom()));
    repeat (PumpSteps) pump_acc(1'b1);
    repeat (PumpSteps) pump_acc(1'b0);
    write_reg(ipds_pkg::REG_GAIN_P, ipds_pkg::GainPReset);
    write_reg(ipds_pkg::REG_GAIN_D, ipds_pkg::GainDReset);
    for (int n = 0; n < 20; n++)
      send_error(pick_error());

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (err_count == 0 && drive_expected.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- incremental_pd_steering_core.f -----
sv/ipds_pkg.sv
sv/ipds_cfg_regs.sv
sv/ipds_incr.sv
sv/ipds_accum.sv
sv/incremental_pd_steering_core.sv
sv/ipds_checker.sv
tb/testbench.sv
